>>> hw/rtl/lcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants of the label contour mask block: register map,
// item commands, payload widths and the control structs passed between units.
// ----------------------------------------------------------------------------
package lcm_pkg;

  // apb register map
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THICK_LINE   = 2'd2;

  // register widths and reset values
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // payload field widths
  localparam int LABEL_W     = 16;
  localparam int PIXEL_ROW_W = 12;
  localparam int PIXEL_COL_W = 11;

  // configuration as held by the register file
  typedef struct packed {
    logic [FRAME_WIDTH_W-1:0]  frame_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    logic                      thick_line;
  } cfg_t;

  // which neighbours of the judged pixel lie inside the frame
  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
  } nb_t;

  // marks of the three upper neighbours
  typedef struct packed {
    logic ul;
    logic uc;
    logic ur;
  } um_t;

endpackage

>>> hw/rtl/lcm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_if
// Valid/ready channels of the label contour mask block: label items in,
// contour marks out.
// ----------------------------------------------------------------------------
interface lcm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [lcm_pkg::LABEL_W-1:0]  label;

  modport source (output valid, output cmd, output label, input ready);
  modport sink   (input valid, input cmd, input label, output ready);
endinterface

interface lcm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             contour_mark;
  logic [lcm_pkg::PIXEL_ROW_W-1:0]  pixel_row;
  logic [lcm_pkg::PIXEL_COL_W-1:0]  pixel_col;
  logic                             frame_last;

  modport source (output valid, output contour_mark, output pixel_row,
                  output pixel_col, output frame_last, input ready);
  modport sink   (input valid, input contour_mark, input pixel_row,
                  input pixel_col, input frame_last, output ready);
endinterface

>>> hw/rtl/lcm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_regs
// APB register file: frame width, frame height and line style. Any write to
// a known register restarts the frame.
// ----------------------------------------------------------------------------
module lcm_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lcm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lcm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output lcm_pkg::cfg_t                    cfg,
  output logic                             restart
);

  logic [lcm_pkg::FRAME_WIDTH_W-1:0]  frame_width_r;
  logic [lcm_pkg::FRAME_HEIGHT_W-1:0] frame_height_r;
  logic                               thick_line_r;
  logic                               wr_en;
  logic [1:0]                         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lcm_pkg::FRAME_WIDTH_RST;
      frame_height_r <= lcm_pkg::FRAME_HEIGHT_RST;
      thick_line_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        lcm_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[lcm_pkg::FRAME_WIDTH_W-1:0];
        lcm_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[lcm_pkg::FRAME_HEIGHT_W-1:0];
        lcm_pkg::REG_THICK_LINE:   thick_line_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // restart on a write to a known register
  always_comb begin
    restart = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        lcm_pkg::REG_FRAME_WIDTH,
        lcm_pkg::REG_FRAME_HEIGHT,
        lcm_pkg::REG_THICK_LINE: restart = 1'b1;
        default:                 restart = 1'b0;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      lcm_pkg::REG_FRAME_WIDTH:  prdata = lcm_pkg::CFG_DATA_W'(frame_width_r);
      lcm_pkg::REG_FRAME_HEIGHT: prdata = lcm_pkg::CFG_DATA_W'(frame_height_r);
      lcm_pkg::REG_THICK_LINE:   prdata = lcm_pkg::CFG_DATA_W'(thick_line_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.frame_width  = frame_width_r;
  assign cfg.frame_height = frame_height_r;
  assign cfg.thick_line   = thick_line_r;

endmodule

>>> hw/rtl/lcm_label_lines.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_label_lines
// Two label line buffers packed in one memory word per column. Read at
// accept, written back one stage later with the rows shifted; the last
// write is forwarded when it hits the column being read.
// ----------------------------------------------------------------------------
module lcm_label_lines #(
  parameter int MAX_WIDTH  = 2048,
  parameter int LABEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
  input  logic [LABEL_BITS-1:0]          wr_value,
  output logic [LABEL_BITS-1:0]          older,
  output logic [LABEL_BITS-1:0]          newer
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [2*LABEL_BITS-1:0] mem [MAX_WIDTH];
  logic [2*LABEL_BITS-1:0] q_r;
  logic [2*LABEL_BITS-1:0] pair;
  logic [2*LABEL_BITS-1:0] wr_data;
  logic                    lw_v_r;
  logic [AW-1:0]           lw_addr_r;
  logic [2*LABEL_BITS-1:0] lw_data_r;

  // resolved pair for the item in the write stage
  assign pair    = (lw_v_r && (lw_addr_r == wr_addr)) ? lw_data_r : q_r;
  assign older   = pair[2*LABEL_BITS-1:LABEL_BITS];
  assign newer   = pair[LABEL_BITS-1:0];
  assign wr_data = {pair[LABEL_BITS-1:0], wr_value};

  // line memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) q_r <= mem[rd_addr];
  end

  // last write, for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (wr_en) begin
      lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

endmodule

>>> hw/rtl/lcm_mark_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_mark_row
// Row of earlier contour marks. The upper-right mark is read from memory at
// accept; upper-center and upper-left come from the previous judgment. The
// last two writes are forwarded over the read taken at accept.
// ----------------------------------------------------------------------------
module lcm_mark_row #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  logic                           adv,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
  input  logic                           wr_mark,
  output lcm_pkg::um_t                   um
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic          mem [MAX_WIDTH];
  logic          q_r;
  logic [AW-1:0] a1_r;
  logic          s2_q_r;
  logic [AW-1:0] s2_a_r;
  logic          h1_v_r;
  logic          h2_v_r;
  logic [AW-1:0] h1_a_r;
  logic [AW-1:0] h2_a_r;
  logic          h1_d_r;
  logic          h2_d_r;
  logic          prev_uc_r;
  logic          prev_ur_r;
  logic          ur;

  // newest write to the same column wins over the memory read
  always_comb begin
    if (h1_v_r && (h1_a_r == s2_a_r))      ur = h1_d_r;
    else if (h2_v_r && (h2_a_r == s2_a_r)) ur = h2_d_r;
    else                                   ur = s2_q_r;
  end

  assign um.ul = prev_uc_r;
  assign um.uc = prev_ur_r;
  assign um.ur = ur;

  // mark memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_mark;
    if (rd_en) q_r <= mem[rd_addr];
  end

  // read data follows its item; neighbour marks carried between judgments
  always_ff @(posedge clk) begin
    if (rd_en) a1_r <= rd_addr;
    if (adv) begin
      s2_q_r <= q_r;
      s2_a_r <= a1_r;
    end
    if (wr_en) begin
      h1_a_r    <= wr_addr;
      h1_d_r    <= wr_mark;
      h2_a_r    <= h1_a_r;
      h2_d_r    <= h1_d_r;
      prev_uc_r <= prev_ur_r;
      prev_ur_r <= (s2_a_r == wr_addr) ? wr_mark : ur;
    end
  end

  // write history valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_v_r <= 1'b0;
      h2_v_r <= 1'b0;
    end else if (wr_en) begin
      h1_v_r <= 1'b1;
      h2_v_r <= h1_v_r;
    end
  end

endmodule

>>> hw/rtl/lcm_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_judge
// Counts in-frame 3x3-window neighbours with a differing label (in thin mode,
// unmarked ones only) and marks the center pixel when more than one counts.
// ----------------------------------------------------------------------------
module lcm_judge #(
  parameter int LABEL_BITS = 16
) (
  input  logic [2:0][2:0][LABEL_BITS-1:0] win,
  input  lcm_pkg::nb_t                    nb,
  input  lcm_pkg::um_t                    um,
  input  logic                            left_mark,
  input  logic                            thick_line,
  output logic                            mark
);

  logic [7:0][LABEL_BITS-1:0] nbl;
  logic [7:0]                 en;
  logic [7:0]                 nmark;
  logic [7:0]                 hit;
  logic [3:0]                 count;

  // neighbours: left, upper-left, up, upper-right, right, lower-right,
  // down, lower-left; win is [column][row]
  always_comb begin
    nbl[0] = win[0][1]; en[0] = nb.left;             nmark[0] = left_mark;
    nbl[1] = win[0][0]; en[1] = nb.left && nb.up;    nmark[1] = um.ul;
    nbl[2] = win[1][0]; en[2] = nb.up;               nmark[2] = um.uc;
    nbl[3] = win[2][0]; en[3] = nb.right && nb.up;   nmark[3] = um.ur;
    nbl[4] = win[2][1]; en[4] = nb.right;            nmark[4] = 1'b0;
    nbl[5] = win[2][2]; en[5] = nb.right && nb.down; nmark[5] = 1'b0;
    nbl[6] = win[1][2]; en[6] = nb.down;             nmark[6] = 1'b0;
    nbl[7] = win[0][2]; en[7] = nb.left && nb.down;  nmark[7] = 1'b0;
  end

  // count differing neighbours that are not already marked in thin mode
  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      hit[i] = en[i] && (nbl[i] != win[1][1]) && (thick_line || !nmark[i]);
      count  = count + 4'(hit[i]);
    end
  end

  assign mark = (count > 4'd1);

endmodule

>>> hw/rtl/label_contour_mask_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_contour_mask_top
// Streaming contour mask over a raster label image.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one item per clock: cmd pixel carries the next label in
//   raster order, cmd drain pushes out pending marks once the last pixel of
//   the frame is in (a drain before that is taken and dropped).
//   out_ch gives one contour mark per pixel with its row, column and a
//   frame_last flag on the final pixel of the frame.
//   The mark of pixel (r,c) is caused by the item frame_width+1 places later
//   in raster order, so a frame needs frame_width+1 drain items after its
//   last pixel. Throughput: one item per clock, sustained while out_ch takes
//   results; the label line memory and the mark row are read at accept and
//   written back as the item leaves stage 1 and stage 2 respectively; marks
//   go out through the output register. When out_ch stalls, one result
//   waits there while the two internal stages fill; in_ch then drops ready.
//   Reset and any write to a known register restart the frame at pixel
//   (0,0); line memories are not cleared and need no clearing pass.
//   Registers: 0x0 frame_width, 0x4 frame_height, 0x8 thick_line.
// ----------------------------------------------------------------------------
module label_contour_mask_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int LABEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lcm_in_if.sink                           in_ch,
  lcm_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lcm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lcm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int RH1 = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = RW + 1;
  localparam int LB  = LABEL_BITS;

  typedef struct packed {
    logic [CW-1:0]  col_in;
    logic [LB-1:0]  value;
    logic           judge;
    logic [RW-1:0]  row;
    logic [CW-1:0]  col;
    lcm_pkg::nb_t   nb;
    logic           last;
  } meta_t;

  lcm_pkg::cfg_t  cfg;
  logic           restart;

  logic [CW1-1:0] w_eff;
  logic [RH1-1:0] h_eff;

  logic [CW-1:0]  in_col_r;
  logic [IRW-1:0] in_row_r;
  logic [CW-1:0]  out_col_r;
  logic [RW-1:0]  out_row_r;
  logic           left_mark_r;

  logic           acc;
  logic           push;
  logic           complete;
  logic           drop;
  logic           col_wrap;
  logic           k_last;
  logic           r_last;
  logic [CW-1:0]  mark_rd_addr;
  meta_t          meta0;

  logic           s1_v_r;
  meta_t          s1_r;
  logic           s2_v_r;
  meta_t          s2_r;
  logic           s2_exit;
  logic           s2_free;
  logic           s1_adv;
  logic           mark_wr;

  logic [2:0][2:0][LB-1:0] win_r;
  logic [LB-1:0]  older;
  logic [LB-1:0]  newer;
  lcm_pkg::um_t   um;
  logic           mark;

  logic                             out_v_r;
  logic                             out_mark_r;
  logic [lcm_pkg::PIXEL_ROW_W-1:0]  out_row_q_r;
  logic [lcm_pkg::PIXEL_COL_W-1:0]  out_col_q_r;
  logic                             out_last_r;

  // register file
  lcm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // effective frame size
  always_comb begin
    if (cfg.frame_width == '0)                  w_eff = CW1'(1);
    else if (32'(cfg.frame_width) > MAX_WIDTH)  w_eff = CW1'(MAX_WIDTH);
    else                                        w_eff = CW1'(cfg.frame_width);
    if (cfg.frame_height == '0)                 h_eff = RH1'(1);
    else if (32'(cfg.frame_height) > MAX_HEIGHT) h_eff = RH1'(MAX_HEIGHT);
    else                                        h_eff = RH1'(cfg.frame_height);
  end

  // pipeline flow
  assign s2_exit     = s2_v_r && (!s2_r.judge || !out_v_r || out_ch.ready);
  assign s2_free     = !s2_v_r || s2_exit;
  assign s1_adv      = s1_v_r && s2_free;
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;
  assign mark_wr     = s2_exit && s2_r.judge;

  // accept stage: position bookkeeping
  assign complete = (in_row_r >= IRW'(h_eff));
  assign drop     = (in_ch.cmd == lcm_pkg::CMD_DRAIN) && !complete;
  assign push     = acc && !drop;
  assign col_wrap = ((CW1'(in_col_r) + CW1'(1)) == w_eff);
  assign k_last   = ((CW1'(out_col_r) + CW1'(1)) == w_eff);
  assign r_last   = ((RH1'(out_row_r) + RH1'(1)) == h_eff);
  assign mark_rd_addr = k_last ? '0 : (out_col_r + CW'(1));

  always_comb begin
    meta0.col_in   = in_col_r;
    meta0.value    = complete ? '0 : LB'(in_ch.label);
    meta0.judge    = !((in_row_r == '0) || ((in_row_r == IRW'(1)) && (in_col_r == '0)));
    meta0.row      = out_row_r;
    meta0.col      = out_col_r;
    meta0.nb.left  = (out_col_r != '0);
    meta0.nb.right = !k_last;
    meta0.nb.up    = (out_row_r != '0);
    meta0.nb.down  = !r_last;
    meta0.last     = r_last && k_last;
  end

  // input and output position counters
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (push) begin
      if (meta0.judge && meta0.last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (col_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + IRW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
        if (meta0.judge) begin
          if (k_last) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RW'(1);
          end else begin
            out_col_r <= out_col_r + CW'(1);
          end
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (push)        s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv)       s2_v_r <= 1'b1;
      else if (s2_exit) s2_v_r <= 1'b0;
    end
  end

  // stage payload and label window
  always_ff @(posedge clk) begin
    if (push) s1_r <= meta0;
    if (s1_adv) begin
      s2_r        <= s1_r;
      win_r[0]    <= win_r[1];
      win_r[1]    <= win_r[2];
      win_r[2][0] <= older;
      win_r[2][1] <= newer;
      win_r[2][2] <= s1_r.value;
    end
  end

  // label line buffers
  lcm_label_lines #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_lines (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (push),
    .rd_addr  (in_col_r),
    .wr_en    (s1_adv),
    .wr_addr  (s1_r.col_in),
    .wr_value (s1_r.value),
    .older    (older),
    .newer    (newer)
  );

  // row of earlier marks
  lcm_mark_row #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_marks (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (push),
    .rd_addr (mark_rd_addr),
    .adv     (s1_adv),
    .wr_en   (mark_wr),
    .wr_addr (s2_r.col),
    .wr_mark (mark),
    .um      (um)
  );

  // neighbour count
  lcm_judge #(
    .LABEL_BITS (LABEL_BITS)
  ) u_judge (
    .win        (win_r),
    .nb         (s2_r.nb),
    .um         (um),
    .left_mark  (left_mark_r),
    .thick_line (cfg.thick_line),
    .mark       (mark)
  );

  // mark of the left neighbour
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      left_mark_r <= 1'b0;
    end else if (mark_wr) begin
      left_mark_r <= mark;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (mark_wr) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_wr) begin
      out_mark_r  <= mark;
      out_row_q_r <= lcm_pkg::PIXEL_ROW_W'(s2_r.row);
      out_col_q_r <= lcm_pkg::PIXEL_COL_W'(s2_r.col);
      out_last_r  <= s2_r.last;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.contour_mark = out_mark_r;
  assign out_ch.pixel_row    = out_row_q_r;
  assign out_ch.pixel_col    = out_col_q_r;
  assign out_ch.frame_last   = out_last_r;

endmodule

>>> tb/label_contour_mask_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_contour_mask_top_tb
// Streams label frames of many sizes through the contour mask block and
// predicts every mark from its own line buffers and 3x3 window. Covers thin
// and thick mode, clamped frame sizes, early drains, pixels that arrive while
// a frame is being flushed, and frames cut short by a register write. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module label_contour_mask_top_tb;
  import lcm_pkg::*;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 4096;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic                   contour_mark;
    logic [PIXEL_ROW_W-1:0] pixel_row;
    logic [PIXEL_COL_W-1:0] pixel_col;
    logic                   frame_last;
  } mark_t;

  // predicts contour marks and keeps the ones still owed by the block
  class contour_scoreboard;
    logic [FRAME_WIDTH_W-1:0]  frame_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    logic                      thick_line;
    logic [LABEL_W-1:0]        older_row [MAX_W];
    logic [LABEL_W-1:0]        newer_row [MAX_W];
    bit                        mark_row [MAX_W];
    logic [LABEL_W-1:0]        window [3][3];  // [column][row]
    bit                        left_mark;
    int unsigned               in_col, in_row, out_col, out_row;
    mark_t                     pending_marks [$];
    int                        errors;

    function new();
      frame_width  = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      thick_line   = 1'b0;
      for (int i = 0; i < MAX_W; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
        mark_row[i]  = 1'b0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) window[i][j] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      left_mark = 1'b0;
    endfunction

    function int unsigned span_w();
      if (frame_width == 0) return 1;
      return (frame_width > MAX_W) ? MAX_W : frame_width;
    endfunction

    function int unsigned span_h();
      if (frame_height == 0) return 1;
      return (frame_height > MAX_H) ? MAX_H : frame_height;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  frame_width  = data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height = data[FRAME_HEIGHT_W-1:0];
        REG_THICK_LINE:   thick_line   = data[0];
        default: return;
      endcase
      restart();
    endfunction

    // returns 0 when the item is an early drain and has no effect
    function bit note_item(logic cmd, logic [LABEL_W-1:0] label);
      int unsigned w, h, c, pos, r, k;
      int x, y, dx, dy, cnt;
      logic [LABEL_W-1:0] value, center;
      bit nb_mark, last;
      mark_t exp;
      w = span_w();
      h = span_h();
      if (cmd == CMD_DRAIN && in_row < h) return 1'b0;
      value = (cmd == CMD_DRAIN || in_row >= h) ? '0 : label;

      // shift one column through line buffers and window
      c = (in_col < w) ? in_col : 0;
      for (int i = 0; i < 3; i++) begin
        window[0][i] = window[1][i];
        window[1][i] = window[2][i];
      end
      window[2][0] = older_row[c];
      window[2][1] = newer_row[c];
      window[2][2] = value;
      older_row[c] = newer_row[c];
      newer_row[c] = value;
      pos = in_row * w + c;
      c++;
      if (c >= w) begin
        c = 0;
        in_row++;
      end
      in_col = c;
      if (pos < w + 1) return 1'b1;

      // judge the window center against its in-frame neighbours
      r = out_row;
      k = out_col;
      center = window[1][1];
      cnt = 0;
      for (dy = -1; dy <= 1; dy++) begin
        for (dx = -1; dx <= 1; dx++) begin
          x = int'(k) + dx;
          y = int'(r) + dy;
          if (dx == 0 && dy == 0) continue;
          if (x < 0 || x >= int'(w) || y < 0 || y >= int'(h)) continue;
          if (window[dx+1][dy+1] == center) continue;
          nb_mark = 1'b0;
          if (dy == -1) nb_mark = mark_row[x];
          else if (dy == 0 && dx == -1) nb_mark = left_mark;
          if (thick_line || !nb_mark) cnt++;
        end
      end

      exp.contour_mark = (cnt > 1);
      if (k > 0) mark_row[k-1] = left_mark;
      left_mark = exp.contour_mark;
      if (k == w - 1) mark_row[k] = exp.contour_mark;
      last = (r == h - 1) && (k == w - 1);
      exp.pixel_row  = r[PIXEL_ROW_W-1:0];
      exp.pixel_col  = k[PIXEL_COL_W-1:0];
      exp.frame_last = last;
      pending_marks.push_back(exp);

      if (last) begin
        restart();
      end else begin
        k++;
        if (k >= w) begin
          k = 0;
          r++;
        end
        out_col = k;
        out_row = r;
      end
      return 1'b1;
    endfunction

    function void check_mark(mark_t got);
      mark_t exp;
      if (pending_marks.size() == 0) begin
        $display("%0t: unexpected mark: expected none, actual row %0d col %0d mark %0b",
                 $time, got.pixel_row, got.pixel_col, got.contour_mark);
        errors++;
        return;
      end
      exp = pending_marks.pop_front();
      if (got.contour_mark !== exp.contour_mark) begin
        $display("%0t: contour_mark at (%0d,%0d): expected %0b actual %0b",
                 $time, exp.pixel_row, exp.pixel_col, exp.contour_mark, got.contour_mark);
        errors++;
      end
      if (got.pixel_row !== exp.pixel_row) begin
        $display("%0t: pixel_row: expected %0d actual %0d",
                 $time, exp.pixel_row, got.pixel_row);
        errors++;
      end
      if (got.pixel_col !== exp.pixel_col) begin
        $display("%0t: pixel_col: expected %0d actual %0d",
                 $time, exp.pixel_col, got.pixel_col);
        errors++;
      end
      if (got.frame_last !== exp.frame_last) begin
        $display("%0t: frame_last at (%0d,%0d): expected %0b actual %0b",
                 $time, exp.pixel_row, exp.pixel_col, exp.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lcm_in_if  in_ch ();
  lcm_out_if out_ch ();

  contour_scoreboard sb = new();
  int                in_idle_pct = 25;
  int                out_stall_pct = 25;
  int                items_sent = 0;
  logic [LABEL_W-1:0] stim_row [MAX_W];

  label_contour_mask_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // accepted marks
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_mark({out_ch.contour_mark, out_ch.pixel_row, out_ch.pixel_col,
                     out_ch.frame_last});
  end

  // apb write: setup, access, then idle
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic configure(input int unsigned w_raw, input int unsigned h_raw,
                           input bit thick, input bit [2:0] which);
    if (which[0]) write_reg(REG_FRAME_WIDTH, {20'($urandom), w_raw[11:0]});
    if (which[1]) write_reg(REG_FRAME_HEIGHT, {19'($urandom), h_raw[12:0]});
    if (which[2]) write_reg(REG_THICK_LINE, {31'($urandom), thick});
  endtask

  task automatic send_item(input logic cmd, input logic [LABEL_W-1:0] label);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.label <= label;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (sb.note_item(cmd, label)) items_sent++;
  endtask

  // one frame of region-like labels, flushed unless cut short
  task automatic send_frame(input bit noisy, input int unsigned cut);
    logic [LABEL_W-1:0] pool [3];
    logic [LABEL_W-1:0] lab;
    int unsigned w, n, col;
    int sel;
    bit scatter;
    w = sb.span_w();
    n = w * sb.span_h();
    scatter = ($urandom_range(9) == 0);
    pool[0] = ($urandom_range(3) == 0) ? '0 : LABEL_W'($urandom);
    pool[1] = ($urandom_range(3) == 0) ? '1 : LABEL_W'($urandom);
    pool[2] = LABEL_W'($urandom);
    for (int unsigned i = 0; i < n && i < cut; i++) begin
      col = i % w;
      if (noisy && $urandom_range(99) < 4) send_item(CMD_DRAIN, LABEL_W'($urandom));
      sel = $urandom_range(99);
      if (scatter) lab = LABEL_W'($urandom);
      else if (sel < 45 && col > 0) lab = stim_row[col-1];
      else if (sel < 70 && i >= w) lab = stim_row[col];
      else lab = pool[$urandom_range(2)];
      stim_row[col] = lab;
      send_item(CMD_PIXEL, lab);
    end
    // flush, sometimes with pixels whose labels are replaced by zero
    if (cut >= n)
      for (int unsigned j = 0; j <= w; j++)
        send_item(($urandom_range(99) < 15) ? CMD_PIXEL : CMD_DRAIN, LABEL_W'($urandom));
  endtask

  // wait for all owed marks plus the pipeline depth
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (sb.pending_marks.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_marks.size() != 0) begin
      $display("%0t: expected %0d more marks, actual none",
               $time, sb.pending_marks.size());
      sb.errors += sb.pending_marks.size();
      sb.pending_marks.delete();
    end
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    int nframes;
    int unsigned w_raw, h_raw, n, cut;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_PIXEL;
    in_ch.label = '0;
    rst_n       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 thin frame: early drain, extreme labels, pixel while flushing
    configure(3, 3, 1'b0, 3'b111);
    send_item(CMD_DRAIN, '1);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0005);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h1234);
    send_item(CMD_DRAIN, '0);
    send_item(CMD_DRAIN, '0);
    send_item(CMD_DRAIN, '0);
    settle();

    // single pixel frame in thick mode
    configure(1, 1, 1'b1, 3'b111);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_DRAIN, '0);
    send_item(CMD_DRAIN, '0);
    settle();

    // zero sizes act as one
    configure(0, 0, 1'b0, 3'b011);
    send_item(CMD_PIXEL, 16'h8000);
    send_item(CMD_DRAIN, '1);
    send_item(CMD_DRAIN, '1);
    settle();

    // random small frames
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase++;
      in_idle_pct   = (phase >= 6 && phase <= 11) ? 0 : 25;
      out_stall_pct = in_idle_pct;
      w_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      h_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      configure(w_raw, h_raw, $urandom_range(1), 3'($urandom_range(1, 7)));
      if ($urandom_range(7) == 0) write_reg(REG_UNMAPPED, $urandom);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        n = sb.span_w() * sb.span_h();
        cut = ($urandom_range(7) == 0) ? $urandom_range(n - 1) : n;
        send_frame($urandom_range(3) == 0, cut);
        if (cut < n) break;
      end
      settle();
    end

    // largest sizes, including clamped register values
    in_idle_pct   = 25;
    out_stall_pct = 25;
    configure(4095, 1, $urandom_range(1), 3'b111);
    send_frame(1'b0, 32'hFFFF_FFFF);
    settle();
    configure(2048, 2, $urandom_range(1), 3'b111);
    send_frame(1'b1, 32'hFFFF_FFFF);
    settle();
    configure(1, 8191, $urandom_range(1), 3'b111);
    send_frame(1'b0, 32'hFFFF_FFFF);
    settle();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lcm_pkg.sv
hw/rtl/lcm_if.sv
hw/rtl/lcm_regs.sv
hw/rtl/lcm_label_lines.sv
hw/rtl/lcm_mark_row.sv
hw/rtl/lcm_judge.sv
hw/rtl/label_contour_mask_top.sv
tb/label_contour_mask_top_tb.sv
